@@ rtl/pit_pkg.sv @@
// Shared constants and types for the point-in-tetrahedron classifier.
package pit_pkg;

  // Default signed coordinate width (Q8.8 at 16 bits).
  localparam int COORD_BITS_DEFAULT = 16;

  // Width of one packed point word on the input ports.
  localparam int FIELD_BITS = 48;

  // Register stages inside one orientation unit.
  localparam int ORIENT_STAGES = 7;

  // Sign of one orientation determinant.
  typedef struct packed {
    logic neg;
    logic zero;
  } orient_sign_t;

endpackage

@@ rtl/pit_orient.sv @@
// Pipelined sign of one 4x4 orientation determinant, formed from a 3x3 of differences.
module pit_orient #(
  parameter int COORD_BITS = pit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic [3*COORD_BITS-1:0]   p,
  input  logic [3*COORD_BITS-1:0]   q,
  input  logic [3*COORD_BITS-1:0]   r,
  input  logic [3*COORD_BITS-1:0]   s,
  output pit_pkg::orient_sign_t     sign
);

  localparam int N   = COORD_BITS;
  localparam int DW  = N + 1;        // coordinate difference
  localparam int PW  = 2 * DW;       // product of two differences
  localparam int CW  = PW + 1;       // cross product component
  localparam int LW  = N + 2;        // low split of a cross component
  localparam int HW  = CW - LW;      // high split of a cross component
  localparam int PLW = DW + LW + 1;  // partial product with the low split
  localparam int PHW = DW + HW;      // partial product with the high split
  localparam int TW  = DW + CW;      // full triple product term
  localparam int SW  = TW + 2;       // sum of three terms

  logic signed [N-1:0]   pc [3];
  logic signed [N-1:0]   qc [3];
  logic signed [N-1:0]   rc [3];
  logic signed [N-1:0]   sc [3];

  logic signed [DW-1:0]  u_s1 [3];
  logic signed [DW-1:0]  v_s1 [3];
  logic signed [DW-1:0]  w_s1 [3];
  logic signed [DW-1:0]  u_s2 [3];
  logic signed [PW-1:0]  m_s2 [6];
  logic signed [DW-1:0]  u_s3 [3];
  logic signed [CW-1:0]  c_s3 [3];
  logic signed [PLW-1:0] pl_s4 [3];
  logic signed [PHW-1:0] ph_s4 [3];
  logic signed [TW-1:0]  t_s5 [3];
  logic signed [SW-1:0]  sum_s6;

  // Split the packed words into signed coordinates, x in the low slot.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pc[k] = $signed(p[k*N +: N]);
      qc[k] = $signed(q[k*N +: N]);
      rc[k] = $signed(r[k*N +: N]);
      sc[k] = $signed(s[k*N +: N]);
    end
  end

  // Stage 1: edge vectors relative to the fourth point.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      u_s1[k] <= $signed({pc[k][N-1], pc[k]}) - $signed({sc[k][N-1], sc[k]});
      v_s1[k] <= $signed({qc[k][N-1], qc[k]}) - $signed({sc[k][N-1], sc[k]});
      w_s1[k] <= $signed({rc[k][N-1], rc[k]}) - $signed({sc[k][N-1], sc[k]});
    end
  end

  // Stage 2: the six products of the cross product v x w.
  always_ff @(posedge clk) begin
    m_s2[0] <= v_s1[1] * w_s1[2];
    m_s2[1] <= v_s1[2] * w_s1[1];
    m_s2[2] <= v_s1[2] * w_s1[0];
    m_s2[3] <= v_s1[0] * w_s1[2];
    m_s2[4] <= v_s1[0] * w_s1[1];
    m_s2[5] <= v_s1[1] * w_s1[0];
    u_s2    <= u_s1;
  end

  // Stage 3: cross product components.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      c_s3[k] <= $signed({m_s2[2*k][PW-1], m_s2[2*k]})
               - $signed({m_s2[2*k+1][PW-1], m_s2[2*k+1]});
    end
    u_s3 <= u_s2;
  end

  // Stage 4: dot product terms, each multiplied in a low and a high half.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pl_s4[k] <= u_s3[k] * $signed({1'b0, c_s3[k][LW-1:0]});
      ph_s4[k] <= u_s3[k] * $signed(c_s3[k][CW-1:LW]);
    end
  end

  // Stage 5: recombine the halves into exact terms.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      t_s5[k] <= ($signed({{(TW-PHW){ph_s4[k][PHW-1]}}, ph_s4[k]}) <<< LW)
               + $signed({{(TW-PLW){pl_s4[k][PLW-1]}}, pl_s4[k]});
    end
  end

  // Stage 6: sum of the three terms gives the determinant.
  always_ff @(posedge clk) begin
    sum_s6 <= $signed({{2{t_s5[0][TW-1]}}, t_s5[0]})
            + $signed({{2{t_s5[1][TW-1]}}, t_s5[1]})
            + $signed({{2{t_s5[2][TW-1]}}, t_s5[2]});
  end

  // Stage 7: sign of the determinant.
  always_ff @(posedge clk) begin
    sign.neg  <= sum_s6[SW-1];
    sign.zero <= (sum_s6 == '0);
  end

endmodule

@@ rtl/point_in_tetrahedron_test.sv @@
// Top level of the point-in-tetrahedron classifier.
//
// Usage: a transaction is offered by raising start with vertex_a..vertex_d and
// query_point on the input ports; it is taken at a rising edge where start is
// high and busy is low. Each word packs three signed COORD_BITS coordinates,
// x in the low bits, then y, then z; bits beyond the 48-bit field read as zero.
// Five orientation units run side by side, one for the whole tetrahedron and
// one for each vertex replaced by the query point, each seven register stages
// deep behind an input register.
// done is high for exactly one cycle once a transaction has passed the input register,
// the orientation stages and the result register, with inside_res and degenerate valid in that cycle.
// Throughput: one transaction per cycle while busy is low; busy drops once reset ends
// and then stays low, since every stage advances each cycle.
// Reset: rst (synchronous, active high) clears all valid bits and holds busy
// high through reset and the cycle after it; transactions in flight are dropped.
// The receiver cannot stall; results are presented once and not held.
module point_in_tetrahedron_test #(
  parameter int COORD_BITS = pit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pit_pkg::FIELD_BITS-1:0] vertex_a,
  input  logic [pit_pkg::FIELD_BITS-1:0] vertex_b,
  input  logic [pit_pkg::FIELD_BITS-1:0] vertex_c,
  input  logic [pit_pkg::FIELD_BITS-1:0] vertex_d,
  input  logic [pit_pkg::FIELD_BITS-1:0] query_point,
  output logic                          done,
  output logic                          inside_res,
  output logic                          degenerate
);

  localparam int PW = 3 * COORD_BITS;
  localparam int XW = 64 - pit_pkg::FIELD_BITS;
  localparam int NS = pit_pkg::ORIENT_STAGES;

  logic [63:0]   a_ext, b_ext, c_ext, d_ext, q_ext;
  logic [PW-1:0] a_s0, b_s0, c_s0, d_s0, q_s0;
  logic [NS:0]   vld;
  logic          accept;

  pit_pkg::orient_sign_t sgn_tot, sgn_1, sgn_2, sgn_3, sgn_4;
  logic                  ok_all;

  assign accept = start && !busy;

  // Busy is only raised by reset; the pipeline takes a transaction every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Zero-extend the fields so that coordinate bits past the field read as zero.
  assign a_ext = {{XW{1'b0}}, vertex_a};
  assign b_ext = {{XW{1'b0}}, vertex_b};
  assign c_ext = {{XW{1'b0}}, vertex_c};
  assign d_ext = {{XW{1'b0}}, vertex_d};
  assign q_ext = {{XW{1'b0}}, query_point};

  // Input register.
  always_ff @(posedge clk) begin
    a_s0 <= a_ext[PW-1:0];
    b_s0 <= b_ext[PW-1:0];
    c_s0 <= c_ext[PW-1:0];
    d_s0 <= d_ext[PW-1:0];
    q_s0 <= q_ext[PW-1:0];
  end

  // Valid bits travel alongside the orientation stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[NS-1:0], accept};
      done <= vld[NS];
    end
  end

  // Orientation of the whole tetrahedron and with the query point in each vertex slot.
  pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_tot (
    .clk(clk), .p(a_s0), .q(b_s0), .r(c_s0), .s(d_s0), .sign(sgn_tot)
  );
  pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_1 (
    .clk(clk), .p(q_s0), .q(b_s0), .r(c_s0), .s(d_s0), .sign(sgn_1)
  );
  pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_2 (
    .clk(clk), .p(a_s0), .q(q_s0), .r(c_s0), .s(d_s0), .sign(sgn_2)
  );
  pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_3 (
    .clk(clk), .p(a_s0), .q(b_s0), .r(q_s0), .s(d_s0), .sign(sgn_3)
  );
  pit_orient #(.COORD_BITS(COORD_BITS)) u_orient_4 (
    .clk(clk), .p(a_s0), .q(b_s0), .r(c_s0), .s(q_s0), .sign(sgn_4)
  );

  // A sub-determinant agrees when it is zero or shares the sign of the total.
  assign ok_all = (sgn_1.zero || (sgn_1.neg == sgn_tot.neg))
               && (sgn_2.zero || (sgn_2.neg == sgn_tot.neg))
               && (sgn_3.zero || (sgn_3.neg == sgn_tot.neg))
               && (sgn_4.zero || (sgn_4.neg == sgn_tot.neg));

  // Result register.
  always_ff @(posedge clk) begin
    degenerate <= sgn_tot.zero;
    inside_res <= !sgn_tot.zero && ok_all;
  end

  // A degenerate tetrahedron never reports the point inside.
  a_degen_not_inside : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> !inside_res)
    else $error("inside_res set on a degenerate tetrahedron");

  // Each result answers a transaction accepted earlier, through the input, orientation and result registers.
  a_done_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, NS + 2))
    else $error("done without a matching accepted transaction");

  // An accepted transaction always produces a result unless reset cuts it off.
  a_accept_done : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(NS + 2) (done || $past(rst, 1) || $past(rst, NS + 1)))
    else $error("accepted transaction produced no result");

endmodule
